// ===== design/cdfb_pkg.sv =====
// Shared types, constants and helper functions of the caller display frame builder.
// Used by the top level, the binary-to-decimal converter and the port checker.
// Depends on nothing else.
`timescale 1ns / 1ps

package cdfb_pkg;

    // Field widths and packing of the input request.
    localparam int OP_W         = 2;
    localparam int ADDR_W       = 8;
    localparam int COUNT_W      = 27;
    localparam int STATUS_W     = 8;
    localparam int DIGITS_W     = 32;
    localparam int NDIG_W       = 4;
    localparam int BYTE_W       = 8;

    localparam int OP_LSB       = 0;
    localparam int ADDR_LSB     = OP_LSB + OP_W;
    localparam int COUNT_LSB    = ADDR_LSB + ADDR_W;
    localparam int STATUS_LSB   = COUNT_LSB + COUNT_W;
    localparam int DIGITS_LSB   = STATUS_LSB + STATUS_W;
    localparam int NDIG_LSB     = DIGITS_LSB + DIGITS_W;
    localparam int IN_FIELDS_W  = NDIG_LSB + NDIG_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_CTRL  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_CTRL = 8'd1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SHOW_COUNT  = 2'd0;
    localparam logic [OP_W-1:0] OP_SHOW_STATUS = 2'd1;
    localparam logic [OP_W-1:0] OP_ALARM       = 2'd2;
    localparam logic [OP_W-1:0] OP_CALL_COUNT  = 2'd3;

    // Frame bytes.
    localparam logic [BYTE_W-1:0] FRAME_START = 8'hFF;
    localparam logic [BYTE_W-1:0] FRAME_MARK  = 8'h68;
    localparam logic [BYTE_W-1:0] FRAME_END   = 8'h16;
    localparam logic [BYTE_W-1:0] CALL_SEP    = 8'h0A;
    localparam logic [BYTE_W-1:0] LEN_EXTRA   = 8'd2;

    // Call-number nibbles and decimal digit limits.
    localparam int CALL_NIBBLES    = 8;
    localparam logic [NDIG_W-1:0] CALL_NIBBLES_MAX = 4'd8;
    localparam logic [3:0] DEC_DIGIT_MAX = 4'd9;
    localparam int MAX_BCD_DIGITS  = 8;
    localparam int DEF_MAX_DIGITS  = 8;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_HDR,
        ST_STAT,
        ST_CALL,
        ST_SEP,
        ST_ZERO,
        ST_CNT,
        ST_SUM,
        ST_END
    } state_t;

    // Ten to the power n, for elaboration-time limits.
    function automatic int pow10(input int n);
        int acc;
        acc = 1;
        for (int i = 0; i < n; i++)
        begin
            acc = acc * 10;
        end
        return acc;
    endfunction

endpackage

// ===== design/cdfb_bin2bcd.sv =====
// Iterative binary-to-decimal converter using the shift-and-add-three method.
// One input bit is consumed per cycle; depends on cdfb_pkg.
`timescale 1ns / 1ps

module cdfb_bin2bcd #(
    parameter int DIGITS = cdfb_pkg::MAX_BCD_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cdfb_pkg::COUNT_W-1:0] value,
    output logic                         done,
    output logic [DIGITS*4-1:0]          bcd
);

    localparam int BcdW = DIGITS * 4;
    localparam int CntW = $clog2(cdfb_pkg::COUNT_W + 1);

    logic                         run_reg;
    logic                         done_reg;
    logic [CntW-1:0]              bit_cnt_reg;
    logic [cdfb_pkg::COUNT_W-1:0] bin_reg;
    logic [BcdW-1:0]              bcd_reg;
    logic [BcdW-1:0]              adj;
    logic [BcdW-1:0]              bcd_next;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
        bcd_next = {adj[BcdW-2:0], bin_reg[cdfb_pkg::COUNT_W-1]};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg     <= 1'b1;
            done_reg    <= 1'b0;
            bit_cnt_reg <= CntW'(cdfb_pkg::COUNT_W);
        end
        else if (run_reg)
        begin
            bit_cnt_reg <= bit_cnt_reg - CntW'(1);
            if (bit_cnt_reg == CntW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (run_reg)
        begin
            bin_reg <= {bin_reg[cdfb_pkg::COUNT_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== design/caller_display_frame_builder.sv =====
// Top level of the caller display frame builder: request latch, frame sequencer,
// output register and configuration registers. Depends on cdfb_pkg and cdfb_bin2bcd.
`timescale 1ns / 1ps

// Usage
// A request on the s_axis channel asks for one display frame; the frame leaves on
// the m_axis channel one byte per transfer, with tlast on the closing 16 byte:
//   FF 68 L L 68 addr ctrl data... sum 16
// Control codes are written on the cfg channel (index 0 show code, index 1 alarm
// code, other indexes ignored); it is always ready and should be used while idle.
// A show-count request with a zero count produces no frame at all.
// After a request the count is turned into decimal digits by a shift-and-add-three
// converter taking one bit a cycle. The sequencer then sends one byte a cycle while
// the receiver keeps tready high, but sends no byte while it skips a non-decimal
// call nibble or while it leaves the call digits.
// s_axis_tready is low from a request until the sequencer is idle again, through
// any stall; a frame has at most 26 bytes.
// When the receiver stalls, the byte waits in the output register and the
// sequencer waits with it. The next request is taken as soon as the closing byte
// is in the output register.
// Reset clears the sequencer, the output valid and both control codes to zero.
module caller_display_frame_builder #(
    parameter int MAX_DIGITS = cdfb_pkg::DEF_MAX_DIGITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cdfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cdfb_pkg::BYTE_W-1:0]        cfg_data,
    // Request channel.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: op[1:0], caller_address[9:2], count_value[36:10], status_byte[44:37],
    //        call_digits[76:45], call_digit_count[80:77], zero pad[87:81]
    input  logic [cdfb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Frame byte channel.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: frame_byte[7:0]
    output logic [cdfb_pkg::BYTE_W-1:0]        m_axis_tdata,
    // tlast: last_byte
    output logic                               m_axis_tlast
);

    localparam int BcdDigits = (MAX_DIGITS > cdfb_pkg::MAX_BCD_DIGITS) ?
                               cdfb_pkg::MAX_BCD_DIGITS : MAX_DIGITS;
    localparam int BcdW      = BcdDigits * 4;
    localparam int DigIdxW   = (BcdDigits > 1) ? $clog2(BcdDigits) : 1;
    localparam int DigCntW   = $clog2(BcdDigits + 1);
    localparam logic [cdfb_pkg::COUNT_W-1:0] CountLimit =
        cdfb_pkg::COUNT_W'(cdfb_pkg::pow10(BcdDigits) - 1);

    // Header byte positions.
    localparam logic [2:0] HDR_START = 3'd0;
    localparam logic [2:0] HDR_MARK1 = 3'd1;
    localparam logic [2:0] HDR_LEN1  = 3'd2;
    localparam logic [2:0] HDR_LEN2  = 3'd3;
    localparam logic [2:0] HDR_MARK2 = 3'd4;
    localparam logic [2:0] HDR_ADDR  = 3'd5;
    localparam logic [2:0] HDR_CTRL  = 3'd6;

    cdfb_pkg::state_t state_reg, state_next;

    logic [2:0]                      hdr_idx_reg, hdr_idx_next;
    logic [cdfb_pkg::NDIG_W-1:0]     left_reg, left_next;
    logic [DigCntW-1:0]              cidx_reg, cidx_next;
    logic [cdfb_pkg::BYTE_W-1:0]     sum_reg, sum_next;

    logic [cdfb_pkg::OP_W-1:0]       op_reg;
    logic [cdfb_pkg::ADDR_W-1:0]     addr_reg;
    logic [cdfb_pkg::STATUS_W-1:0]   status_reg;
    logic [cdfb_pkg::DIGITS_W-1:0]   digits_reg;
    logic [cdfb_pkg::NDIG_W-1:0]     ndig_reg;

    logic [cdfb_pkg::BYTE_W-1:0]     show_ctrl_reg;
    logic [cdfb_pkg::BYTE_W-1:0]     alarm_ctrl_reg;

    logic                            ovalid_reg;
    logic [cdfb_pkg::BYTE_W-1:0]     odata_reg;
    logic                            olast_reg;

    logic                            accept;
    logic [cdfb_pkg::COUNT_W-1:0]    in_count;
    logic [cdfb_pkg::COUNT_W-1:0]    count_sat;
    logic [cdfb_pkg::NDIG_W-1:0]     in_ndig;
    logic                            conv_done;
    logic [BcdW-1:0]                 conv_bcd;

    logic [DigCntW-1:0]              ndec;
    logic [3:0]                      ncall;
    logic [4:0]                      data_n;
    logic [cdfb_pkg::BYTE_W-1:0]     frame_len;
    logic [cdfb_pkg::BYTE_W-1:0]     ctrl_byte;
    logic [2:0]                      nib_sel;
    logic [3:0]                      call_nib;
    logic [DigIdxW-1:0]              dig_sel;
    logic [3:0]                      cnt_dig;

    logic                            emit_ok;
    logic                            emit_en;
    logic [cdfb_pkg::BYTE_W-1:0]     emit_byte;
    logic                            emit_last;

    assign s_axis_tready = (state_reg == cdfb_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Request unpacking and count saturation.
    assign in_count  = s_axis_tdata[cdfb_pkg::COUNT_LSB +: cdfb_pkg::COUNT_W];
    assign count_sat = (in_count > CountLimit) ? CountLimit : in_count;
    assign in_ndig   = s_axis_tdata[cdfb_pkg::NDIG_LSB +: cdfb_pkg::NDIG_W];

    cdfb_bin2bcd #(
        .DIGITS (BcdDigits)
    ) u_bin2bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (count_sat),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    // Significant decimal digits and decimal call nibbles.
    always_comb
    begin
        ndec  = '0;
        ncall = 4'd0;
        for (int i = 0; i < BcdDigits; i++)
        begin
            if (conv_bcd[i*4 +: 4] != 4'd0)
                ndec = DigCntW'(i + 1);
        end
        for (int i = 0; i < cdfb_pkg::CALL_NIBBLES; i++)
        begin
            if ((4'(i) < ndig_reg) && (digits_reg[i*4 +: 4] <= cdfb_pkg::DEC_DIGIT_MAX))
                ncall = ncall + 4'd1;
        end
    end

    // Data byte count and length field.
    always_comb
    begin
        case (op_reg)
            cdfb_pkg::OP_SHOW_COUNT:  data_n = 5'(ndec);
            cdfb_pkg::OP_SHOW_STATUS: data_n = 5'd1;
            cdfb_pkg::OP_ALARM:       data_n = 5'd0;
            default:
            begin
                if (ndec == '0)
                    data_n = 5'(ncall) + 5'd2;
                else
                    data_n = 5'(ncall) + 5'd1 + 5'(ndec);
            end
        endcase
        frame_len = 8'(data_n) + cdfb_pkg::LEN_EXTRA;
        ctrl_byte = (op_reg == cdfb_pkg::OP_ALARM) ? alarm_ctrl_reg : show_ctrl_reg;
    end

    // Current call nibble and count digit.
    assign nib_sel  = 3'(left_reg - 4'd1);
    assign call_nib = digits_reg[{nib_sel, 2'b00} +: 4];
    assign dig_sel  = DigIdxW'(cidx_reg - DigCntW'(1));
    assign cnt_dig  = conv_bcd[dig_sel*4 +: 4];

    assign emit_ok = !ovalid_reg || m_axis_tready;

    // Sequencer: next state and the byte to send.
    always_comb
    begin
        state_next   = state_reg;
        hdr_idx_next = hdr_idx_reg;
        left_next    = left_reg;
        cidx_next    = cidx_reg;
        sum_next     = sum_reg;
        emit_en      = 1'b0;
        emit_byte    = '0;
        emit_last    = 1'b0;
        case (state_reg)
            cdfb_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = cdfb_pkg::ST_CONV;
            end
            cdfb_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    hdr_idx_next = HDR_START;
                    if ((op_reg == cdfb_pkg::OP_SHOW_COUNT) && (ndec == '0))
                        state_next = cdfb_pkg::ST_IDLE;
                    else
                        state_next = cdfb_pkg::ST_HDR;
                end
            end
            cdfb_pkg::ST_HDR:
            begin
                if (emit_ok)
                begin
                    emit_en      = 1'b1;
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                    case (hdr_idx_reg)
                        HDR_START: emit_byte = cdfb_pkg::FRAME_START;
                        HDR_MARK1: emit_byte = cdfb_pkg::FRAME_MARK;
                        HDR_LEN1:  emit_byte = frame_len;
                        HDR_LEN2:  emit_byte = frame_len;
                        HDR_MARK2: emit_byte = cdfb_pkg::FRAME_MARK;
                        HDR_ADDR:
                        begin
                            emit_byte = addr_reg;
                            sum_next  = addr_reg;
                        end
                        default:
                        begin
                            emit_byte = ctrl_byte;
                            sum_next  = sum_reg + ctrl_byte;
                        end
                    endcase
                    if (hdr_idx_reg == HDR_CTRL)
                    begin
                        left_next = ndig_reg;
                        cidx_next = ndec;
                        case (op_reg)
                            cdfb_pkg::OP_SHOW_COUNT:  state_next = cdfb_pkg::ST_CNT;
                            cdfb_pkg::OP_SHOW_STATUS: state_next = cdfb_pkg::ST_STAT;
                            cdfb_pkg::OP_ALARM:       state_next = cdfb_pkg::ST_SUM;
                            default:                  state_next = cdfb_pkg::ST_CALL;
                        endcase
                    end
                end
            end
            cdfb_pkg::ST_STAT:
            begin
                if (emit_ok)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = status_reg;
                    sum_next   = sum_reg + status_reg;
                    state_next = cdfb_pkg::ST_SUM;
                end
            end
            cdfb_pkg::ST_CALL:
            begin
                if (left_reg == 4'd0)
                    state_next = cdfb_pkg::ST_SEP;
                else if (call_nib > cdfb_pkg::DEC_DIGIT_MAX)
                    left_next = left_reg - 4'd1;
                else if (emit_ok)
                begin
                    emit_en   = 1'b1;
                    emit_byte = 8'(call_nib);
                    sum_next  = sum_reg + 8'(call_nib);
                    left_next = left_reg - 4'd1;
                end
            end
            cdfb_pkg::ST_SEP:
            begin
                if (emit_ok)
                begin
                    emit_en   = 1'b1;
                    emit_byte = cdfb_pkg::CALL_SEP;
                    sum_next  = sum_reg + cdfb_pkg::CALL_SEP;
                    if (ndec == '0)
                        state_next = cdfb_pkg::ST_ZERO;
                    else
                        state_next = cdfb_pkg::ST_CNT;
                end
            end
            cdfb_pkg::ST_ZERO:
            begin
                if (emit_ok)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = '0;
                    state_next = cdfb_pkg::ST_SUM;
                end
            end
            cdfb_pkg::ST_CNT:
            begin
                if (emit_ok)
                begin
                    emit_en   = 1'b1;
                    emit_byte = 8'(cnt_dig);
                    sum_next  = sum_reg + 8'(cnt_dig);
                    cidx_next = cidx_reg - DigCntW'(1);
                    if (cidx_reg == DigCntW'(1))
                        state_next = cdfb_pkg::ST_SUM;
                end
            end
            cdfb_pkg::ST_SUM:
            begin
                if (emit_ok)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = sum_reg;
                    state_next = cdfb_pkg::ST_END;
                end
            end
            cdfb_pkg::ST_END:
            begin
                if (emit_ok)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = cdfb_pkg::FRAME_END;
                    emit_last  = 1'b1;
                    state_next = cdfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cdfb_pkg::ST_IDLE;
            hdr_idx_reg <= HDR_START;
            left_reg    <= '0;
            cidx_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hdr_idx_reg <= hdr_idx_next;
            left_reg    <= left_next;
            cidx_reg    <= cidx_next;
        end
    end

    // Running checksum.
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // Request latch; the call digit count is clamped to eight nibbles.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_axis_tdata[cdfb_pkg::OP_LSB +: cdfb_pkg::OP_W];
            addr_reg   <= s_axis_tdata[cdfb_pkg::ADDR_LSB +: cdfb_pkg::ADDR_W];
            status_reg <= s_axis_tdata[cdfb_pkg::STATUS_LSB +: cdfb_pkg::STATUS_W];
            digits_reg <= s_axis_tdata[cdfb_pkg::DIGITS_LSB +: cdfb_pkg::DIGITS_W];
            ndig_reg   <= (in_ndig > cdfb_pkg::CALL_NIBBLES_MAX) ?
                          cdfb_pkg::CALL_NIBBLES_MAX : in_ndig;
        end
    end

    // Control code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_ctrl_reg  <= '0;
            alarm_ctrl_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cdfb_pkg::CFG_SHOW_CTRL:  show_ctrl_reg  <= cfg_data;
                cdfb_pkg::CFG_ALARM_CTRL: alarm_ctrl_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (emit_en)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            odata_reg <= emit_byte;
            olast_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// ===== design/cdfb_checker.sv =====
// Port-level checks for the caller display frame builder, bound to the top level.
// Depends on cdfb_pkg and on the top level's port names.
`timescale 1ns / 1ps

module cdfb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [cdfb_pkg::BYTE_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast
);

    // A stalled frame byte holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("frame byte changed while stalled");

    // The block is busy for at least the cycle after taking a request.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken on consecutive cycles");

    // The closing byte is always the end code.
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == cdfb_pkg::FRAME_END)
        else $error("last byte is not the end code");

    // No frame byte is produced at the edge that takes a request, so the output
    // holds still over the cycle that follows it.
    a_start_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || m_axis_tlast ||
        $stable(m_axis_tdata))
        else $error("frame byte changed on the cycle after a request");

endmodule

bind caller_display_frame_builder cdfb_checker u_cdfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
